### rtl/apf_pkg.sv
// Shared constants, opcodes and the CRC-32 step for the two-axis position block.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package apf_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned FRAME_WORDS = 5;
  localparam int unsigned WIDX_W      = 3;

  localparam logic [WORD_W-1:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_FRAME_WORD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_LONG   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_CROSS  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEFTWARD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_DOWNWARD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TOOL     = 3'd4;

  // One word of the reflected IEEE CRC-32; the loop is a fixed XOR network.
  function automatic logic [WORD_W-1:0] crc32_word(input logic [WORD_W-1:0] crc,
                                                   input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] c;
    c = crc ^ word;
    for (int b = 0; b < WORD_W; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/apf_in_if.sv
// Request channel of the two-axis position block: valid/ready plus one request.
// Depends on apf_pkg for field widths.
`default_nettype none

interface apf_in_if;
  logic                               valid;
  logic                               ready;
  logic [apf_pkg::OPCODE_W-1:0]       opcode;
  logic [apf_pkg::WORD_W-1:0]         frame_word;
  logic [apf_pkg::SLOT_W-1:0]         tool_slot;
  logic signed [apf_pkg::WORD_W-1:0]  wanted_position;

  modport source (output valid, opcode, frame_word, tool_slot, wanted_position,
                  input ready);
  modport sink   (input valid, opcode, frame_word, tool_slot, wanted_position,
                  output ready);
endinterface

`default_nettype wire

### rtl/apf_out_if.sv
// Result channel of the two-axis position block: valid/ready plus one result.
// Depends on apf_pkg for field widths.
`default_nettype none

interface apf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [apf_pkg::WORD_W-1:0]  long_position;
  logic signed [apf_pkg::WORD_W-1:0]  cross_position;
  logic signed [apf_pkg::WORD_W-1:0]  long_speed;
  logic signed [apf_pkg::WORD_W-1:0]  cross_velocity;
  logic                               crc_error;

  modport source (output valid, long_position, cross_position, long_speed,
                  cross_velocity, crc_error, input ready);
  modport sink   (input valid, long_position, cross_position, long_speed,
                  cross_velocity, crc_error, output ready);
endinterface

`default_nettype wire

### rtl/axis_position_frame_with_tool_offsets.sv
// Top level of the two-axis encoder position block with a per-tool offset table.
// Depends on apf_pkg, apf_in_if and apf_out_if.
//
// Usage: requests enter on item (valid/ready). Opcode 0 carries one word of a
// five-word encoder frame; the first four words are buffered and give no
// result, the fifth is checked as the CRC-32 and gives one result. Opcodes 1
// and 2 set the longitudinal or cross offset of a tool slot so that the axis
// reads the wanted position, and each gives one result. Opcode 3 is dropped.
// Results leave on result (valid/ready) with both positions for the active
// tool, the two speeds and the CRC error flag.
// A request passes through the request register and the processing stage, whose
// output is registered. One request is taken every cycle unless result stalls;
// the rate is set by the single processing stage, which holds the CRC-32 word
// step and four parallel 32x16 scale multipliers, applied when a correct CRC
// word closes a frame. When result is stalled, the pending result stays in its
// register and the request register still fills, so one more request is taken
// before item.ready drops if that register was empty. Reset (synchronous, rst
// high) clears the frame position, CRC, scaled positions, speeds and tool
// offsets, and loads the configuration defaults. Configuration is written on
// cfg_wr_en/cfg_index/cfg_data only while idle, by the user; not enforced.
`default_nettype none

module axis_position_frame_with_tool_offsets #(
  parameter int unsigned TOOL_SLOTS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [apf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [apf_pkg::CFG_DATA_W-1:0]      cfg_data,
  apf_in_if.sink                                   item,
  apf_out_if.source                                result
);

  // The slot field is three bits wide, so no more than eight slots are reachable.
  localparam int unsigned SlotsUsed = (TOOL_SLOTS < (1 << apf_pkg::SLOT_W)) ?
                                      TOOL_SLOTS : (1 << apf_pkg::SLOT_W);

  // Configuration registers.
  logic [apf_pkg::SCALE_W-1:0] long_scale;
  logic [apf_pkg::SCALE_W-1:0] cross_scale;
  logic                        long_leftward;
  logic                        cross_downward;
  logic [apf_pkg::SLOT_W-1:0]  active_tool;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_scale     <= apf_pkg::SCALE_W'(1);
      cross_scale    <= apf_pkg::SCALE_W'(1);
      long_leftward  <= 1'b1;
      cross_downward <= 1'b1;
      active_tool    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        apf_pkg::CFG_LONG_SCALE:     long_scale     <= cfg_data;
        apf_pkg::CFG_CROSS_SCALE:    cross_scale    <= cfg_data;
        apf_pkg::CFG_LONG_LEFTWARD:  long_leftward  <= cfg_data[0];
        apf_pkg::CFG_CROSS_DOWNWARD: cross_downward <= cfg_data[0];
        apf_pkg::CFG_ACTIVE_TOOL:    active_tool    <= cfg_data[apf_pkg::SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request register.
  logic                           s_valid;
  logic [apf_pkg::OPCODE_W-1:0]   s_opcode;
  logic [apf_pkg::WORD_W-1:0]     s_word;
  logic [apf_pkg::SLOT_W-1:0]     s_slot;
  logic [apf_pkg::WORD_W-1:0]     s_wanted;
  logic                           advance;
  logic                           res_valid;

  assign advance    = s_valid && (!res_valid || result.ready);
  assign item.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s_opcode <= item.opcode;
      s_word   <= item.frame_word;
      s_slot   <= item.tool_slot;
      s_wanted <= item.wanted_position;
    end
  end

  // Processing state.
  logic [apf_pkg::WIDX_W-1:0]  word_index;
  logic [apf_pkg::WORD_W-1:0]  crc_running;
  logic [apf_pkg::WORD_W-1:0]  raw_long;
  logic [apf_pkg::WORD_W-1:0]  cross_count_pos;
  logic [apf_pkg::WORD_W-1:0]  speed_long;
  logic [apf_pkg::WORD_W-1:0]  speed_cross;
  logic [apf_pkg::WORD_W-1:0]  long_offsets  [SlotsUsed];
  logic [apf_pkg::WORD_W-1:0]  cross_offsets [SlotsUsed];
  // Frame words are kept as received; the scales in force when the CRC word
  // arrives are the ones applied.
  logic [apf_pkg::WORD_W-1:0]  frame_store   [apf_pkg::FRAME_WORDS-1];

  logic                        is_word;
  logic                        is_set_long;
  logic                        is_set_cross;
  logic                        last_word;
  logic                        crc_bad;
  logic                        good_end;
  logic                        emit;
  logic [apf_pkg::WORD_W-1:0]  crc_next;
  logic [apf_pkg::WORD_W+apf_pkg::SCALE_W-1:0] mul_long_pos;
  logic [apf_pkg::WORD_W+apf_pkg::SCALE_W-1:0] mul_cross_pos;
  logic [apf_pkg::WORD_W+apf_pkg::SCALE_W-1:0] mul_cross_rate;
  logic [apf_pkg::WORD_W+apf_pkg::SCALE_W-1:0] mul_long_rate;
  logic                        slot_in_table;
  logic [apf_pkg::WORD_W-1:0]  long_off_wr;
  logic [apf_pkg::WORD_W-1:0]  cross_off_wr;
  logic [apf_pkg::WORD_W-1:0]  long_off_cur;
  logic [apf_pkg::WORD_W-1:0]  cross_off_cur;
  logic [apf_pkg::WORD_W-1:0]  long_off_eff;
  logic [apf_pkg::WORD_W-1:0]  cross_off_eff;
  logic [apf_pkg::WORD_W-1:0]  raw_long_next;
  logic [apf_pkg::WORD_W-1:0]  cross_count_pos_next;
  logic [apf_pkg::WORD_W-1:0]  speed_long_next;
  logic [apf_pkg::WORD_W-1:0]  speed_cross_next;
  logic [apf_pkg::WORD_W-1:0]  long_pos;
  logic [apf_pkg::WORD_W-1:0]  cross_pos;

  assign is_word      = (s_opcode == apf_pkg::OP_FRAME_WORD);
  assign is_set_long  = (s_opcode == apf_pkg::OP_SET_LONG);
  assign is_set_cross = (s_opcode == apf_pkg::OP_SET_CROSS);
  assign last_word    = (word_index == apf_pkg::WIDX_W'(apf_pkg::FRAME_WORDS - 1));
  assign crc_next     = apf_pkg::crc32_word(crc_running, s_word);
  assign crc_bad      = ((crc_running ^ apf_pkg::CRC_PRESET) != s_word);
  assign good_end     = is_word && last_word && !crc_bad;
  assign emit         = (is_word && last_word) || is_set_long || is_set_cross;

  // Words 0 and 3 are longitudinal, 1 and 2 cross; speeds carry an extra factor.
  assign mul_long_pos   = {{apf_pkg::SCALE_W{1'b0}}, frame_store[0]} *
                          {{apf_pkg::WORD_W{1'b0}}, long_scale};
  assign mul_cross_pos  = {{apf_pkg::SCALE_W{1'b0}}, frame_store[1]} *
                          {{apf_pkg::WORD_W{1'b0}}, cross_scale};
  assign mul_cross_rate = {{apf_pkg::SCALE_W{1'b0}}, frame_store[2]} *
                          {{apf_pkg::WORD_W{1'b0}}, cross_scale};
  assign mul_long_rate  = {{apf_pkg::SCALE_W{1'b0}}, frame_store[3]} *
                          {{apf_pkg::WORD_W{1'b0}}, long_scale};

  assign raw_long_next        = good_end ? mul_long_pos[apf_pkg::WORD_W-1:0] : raw_long;
  assign cross_count_pos_next = good_end ? mul_cross_pos[apf_pkg::WORD_W-1:0]
                                         : cross_count_pos;
  assign speed_cross_next     = good_end ? (mul_cross_rate[apf_pkg::WORD_W-1:0] << 3)
                                         : speed_cross;
  assign speed_long_next      = good_end ? (mul_long_rate[apf_pkg::WORD_W-1:0] << 2)
                                         : speed_long;

  assign slot_in_table = ({1'b0, s_slot} < (apf_pkg::SLOT_W + 1)'(SlotsUsed));
  assign long_off_wr   = long_leftward  ? (s_wanted + raw_long)  : (raw_long - s_wanted);
  assign cross_off_wr  = cross_downward ? (cross_count_pos - s_wanted)
                                        : (s_wanted + cross_count_pos);

  // Offsets of the active tool; a tool beyond the table reads as zero.
  always_comb begin
    long_off_cur  = '0;
    cross_off_cur = '0;
    for (int i = 0; i < SlotsUsed; i++) begin
      if (active_tool == apf_pkg::SLOT_W'(i)) begin
        long_off_cur  = long_offsets[i];
        cross_off_cur = cross_offsets[i];
      end
    end
  end

  // A set request on the active tool shows its new offset in its own result.
  always_comb begin
    long_off_eff  = long_off_cur;
    cross_off_eff = cross_off_cur;
    if (slot_in_table && s_slot == active_tool) begin
      if (is_set_long) begin
        long_off_eff = long_off_wr;
      end
      if (is_set_cross) begin
        cross_off_eff = cross_off_wr;
      end
    end
  end

  assign long_pos  = long_leftward  ? (long_off_eff - raw_long_next)
                                    : (raw_long_next - long_off_eff);
  assign cross_pos = cross_downward ? (cross_count_pos_next - cross_off_eff)
                                    : (cross_off_eff - cross_count_pos_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index      <= '0;
      crc_running     <= apf_pkg::CRC_PRESET;
      raw_long        <= '0;
      cross_count_pos <= '0;
      speed_long      <= '0;
      speed_cross     <= '0;
      for (int i = 0; i < SlotsUsed; i++) begin
        long_offsets[i]  <= '0;
        cross_offsets[i] <= '0;
      end
    end else if (advance) begin
      raw_long        <= raw_long_next;
      cross_count_pos <= cross_count_pos_next;
      speed_long      <= speed_long_next;
      speed_cross     <= speed_cross_next;
      if (is_word) begin
        if (last_word) begin
          word_index  <= '0;
          crc_running <= apf_pkg::CRC_PRESET;
        end else begin
          word_index  <= word_index + apf_pkg::WIDX_W'(1);
          crc_running <= crc_next;
        end
      end
      for (int i = 0; i < SlotsUsed; i++) begin
        if (s_slot == apf_pkg::SLOT_W'(i)) begin
          if (is_set_long) begin
            long_offsets[i] <= long_off_wr;
          end
          if (is_set_cross) begin
            cross_offsets[i] <= cross_off_wr;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_word && !last_word) begin
      for (int i = 0; i < apf_pkg::FRAME_WORDS - 1; i++) begin
        if (word_index == apf_pkg::WIDX_W'(i)) begin
          frame_store[i] <= s_word;
        end
      end
    end
  end

  // Result register.
  logic [apf_pkg::WORD_W-1:0] res_long_pos;
  logic [apf_pkg::WORD_W-1:0] res_cross_pos;
  logic [apf_pkg::WORD_W-1:0] res_long_speed;
  logic [apf_pkg::WORD_W-1:0] res_cross_rate;
  logic                       res_crc_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_long_pos   <= long_pos;
      res_cross_pos  <= cross_pos;
      res_long_speed <= speed_long_next;
      res_cross_rate <= speed_cross_next;
      res_crc_error  <= is_word && crc_bad;
    end
  end

  assign result.valid          = res_valid;
  assign result.long_position  = $signed(res_long_pos);
  assign result.cross_position = $signed(res_cross_pos);
  assign result.long_speed     = $signed(res_long_speed);
  assign result.cross_velocity = $signed(res_cross_rate);
  assign result.crc_error      = res_crc_error;

endmodule

`default_nettype wire

### tb/apf_tb_pkg.sv
// Expected-position tracker for the two-axis position block testbench.
// Depends on apf_pkg for widths, opcodes, register indexes and CRC constants.
package apf_tb_pkg;
  import apf_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] long_position;
    logic signed [WORD_W-1:0] cross_position;
    logic signed [WORD_W-1:0] long_speed;
    logic signed [WORD_W-1:0] cross_velocity;
    logic                     crc_error;
  } position_t;

  class position_tracker;
    logic [SCALE_W-1:0] long_scale;
    logic [SCALE_W-1:0] cross_scale;
    logic               long_leftward;
    logic               cross_downward;
    logic [SLOT_W-1:0]  active_tool;

    logic [WIDX_W-1:0]  word_idx;
    logic [WORD_W-1:0]  crc_acc;
    logic [WORD_W-1:0]  frame_words [FRAME_WORDS-1];
    logic [WORD_W-1:0]  raw_long;
    logic [WORD_W-1:0]  cross_count_pos;
    logic [WORD_W-1:0]  speed_long;
    logic [WORD_W-1:0]  speed_cross;
    logic [WORD_W-1:0]  long_ofs [8];
    logic [WORD_W-1:0]  cross_ofs [8];

    position_t pending_positions [$];
    int        errors;

    function new();
      long_scale      = 1;
      cross_scale     = 1;
      long_leftward   = 1'b1;
      cross_downward  = 1'b1;
      active_tool     = '0;
      word_idx        = '0;
      crc_acc         = CRC_PRESET;
      raw_long        = '0;
      cross_count_pos = '0;
      speed_long      = '0;
      speed_cross     = '0;
      foreach (long_ofs[i]) begin
        long_ofs[i]  = '0;
        cross_ofs[i] = '0;
      end
      errors = 0;
    endfunction

    // Shifts the word in least significant bit first, one polynomial step per bit.
    static function logic [WORD_W-1:0] crc_fold(logic [WORD_W-1:0] crc,
                                                logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] c;
      logic              fb;
      c = crc;
      for (int i = 0; i < WORD_W; i++) begin
        fb = c[0] ^ word[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LONG_SCALE:     long_scale = data[SCALE_W-1:0];
        CFG_CROSS_SCALE:    cross_scale = data[SCALE_W-1:0];
        CFG_LONG_LEFTWARD:  long_leftward = data[0];
        CFG_CROSS_DOWNWARD: cross_downward = data[0];
        CFG_ACTIVE_TOOL:    active_tool = data[SLOT_W-1:0];
        default: ;
      endcase
    endfunction

    function position_t report_now(logic err);
      position_t         p;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] co;
      lo = long_ofs[active_tool];
      co = cross_ofs[active_tool];
      p.long_position  = long_leftward ? lo - raw_long : raw_long - lo;
      p.cross_position = cross_downward ? cross_count_pos - co : co - cross_count_pos;
      p.long_speed     = speed_long;
      p.cross_velocity = speed_cross;
      p.crc_error      = err;
      return p;
    endfunction

    function void track_request(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] word,
                                logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] wanted);
      logic err;
      case (op)
        OP_FRAME_WORD: begin
          if (word_idx < FRAME_WORDS - 1) begin
            frame_words[word_idx] = word;
            crc_acc  = crc_fold(crc_acc, word);
            word_idx = word_idx + 1'b1;
          end else begin
            err = ((crc_acc ^ CRC_PRESET) != word);
            if (!err) begin
              raw_long        = frame_words[0] * WORD_W'(long_scale);
              cross_count_pos = frame_words[1] * WORD_W'(cross_scale);
              speed_cross     = frame_words[2] * WORD_W'(cross_scale) * 32'd8;
              speed_long      = frame_words[3] * WORD_W'(long_scale) * 32'd4;
            end
            word_idx = '0;
            crc_acc  = CRC_PRESET;
            pending_positions.push_back(report_now(err));
          end
        end
        OP_SET_LONG: begin
          long_ofs[slot] = long_leftward ? wanted + raw_long : raw_long - wanted;
          pending_positions.push_back(report_now(1'b0));
        end
        OP_SET_CROSS: begin
          cross_ofs[slot] = cross_downward ? cross_count_pos - wanted
                                           : wanted + cross_count_pos;
          pending_positions.push_back(report_now(1'b0));
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(position_t got);
      position_t exp_p;
      if (pending_positions.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp_p = pending_positions.pop_front();
      compare("long_position", exp_p.long_position, got.long_position);
      compare("cross_position", exp_p.cross_position, got.cross_position);
      compare("long_speed", exp_p.long_speed, got.long_speed);
      compare("cross_velocity", exp_p.cross_velocity, got.cross_velocity);
      compare("crc_error", WORD_W'(exp_p.crc_error), WORD_W'(got.crc_error));
    endfunction

    function int pending();
      return pending_positions.size();
    endfunction
  endclass

endpackage

### tb/tb.sv
// Top-level testbench of the two-axis position block: drives frames and tool
// offset requests with random gaps and checks each result against the tracker.
// Depends on apf_pkg, apf_in_if, apf_out_if and apf_tb_pkg.
module tb;
  import apf_pkg::*;
  import apf_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  apf_in_if  item_if ();
  apf_out_if result_if ();

  axis_position_frame_with_tool_offsets u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  position_tracker tracker = new();

  int                send_idle_pct;
  int                recv_idle_pct;
  int                sent_count;
  bit                hold_req;
  logic [SLOT_W-1:0] cur_tool;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signals are stable at the falling edge, so both handshakes are observed there.
  always @(negedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready)
        tracker.track_request(item_if.opcode, item_if.frame_word, item_if.tool_slot,
                              item_if.wanted_position);
      if (result_if.valid && result_if.ready)
        tracker.check_result({result_if.long_position, result_if.cross_position,
                              result_if.long_speed, result_if.cross_velocity,
                              result_if.crc_error});
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        stall = 0;
      else
        stall++;
      if (stall >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word,
                          input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] wanted);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid           <= 1'b1;
    item_if.opcode          <= op;
    item_if.frame_word      <= word;
    item_if.tool_slot       <= slot;
    item_if.wanted_position <= wanted;
    do @(negedge clk); while (!item_if.ready);
    @(posedge clk);
    if (op != OP_UNUSED) sent_count++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return WORD_W'($urandom_range(1000));
      3: return -WORD_W'($urandom_range(1000));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_wanted();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_setting();
    logic [SLOT_W-1:0] slot;
    slot = $urandom_range(1) ? cur_tool : SLOT_W'($urandom_range(7));
    send_req($urandom_range(1) ? OP_SET_LONG : OP_SET_CROSS, $urandom(), slot, pick_wanted());
  endtask

  // Sends one frame, now and then with a set or dropped request slipped in.
  task automatic send_frame(input logic [WORD_W-1:0] w [FRAME_WORDS-1], input bit corrupt,
                            input bit mix);
    logic [WORD_W-1:0] crc;
    logic [WORD_W-1:0] flip;
    crc = CRC_PRESET;
    for (int i = 0; i < FRAME_WORDS - 1; i++) begin
      if (mix && $urandom_range(9) == 0) begin
        if ($urandom_range(2) == 0)
          send_req(OP_UNUSED, $urandom(), SLOT_W'($urandom_range(7)), $urandom());
        else
          send_setting();
      end
      crc = position_tracker::crc_fold(crc, w[i]);
      send_req(OP_FRAME_WORD, w[i], SLOT_W'($urandom_range(7)), $urandom());
    end
    flip = '0;
    if (corrupt) begin
      flip = $urandom();
      if (flip == '0) flip = 32'h1;
    end
    send_req(OP_FRAME_WORD, ~crc ^ flip, SLOT_W'($urandom_range(7)), $urandom());
  endtask

  task automatic send_random_frame(input bit corrupt);
    logic [WORD_W-1:0] w [FRAME_WORDS-1];
    foreach (w[i]) w[i] = pick_word();
    send_frame(w, corrupt, 1'b1);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_cfg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [SCALE_W-1:0] ls, input logic [SCALE_W-1:0] cs,
                            input logic lw, input logic cd, input logic [SLOT_W-1:0] tool);
    cfg_write(CFG_LONG_SCALE, ls);
    cfg_write(CFG_CROSS_SCALE, cs);
    cfg_write(CFG_LONG_LEFTWARD, CFG_DATA_W'(lw));
    cfg_write(CFG_CROSS_DOWNWARD, CFG_DATA_W'(cd));
    cfg_write(CFG_ACTIVE_TOOL, CFG_DATA_W'(tool));
    cfg_wr_en <= 1'b0;
    cur_tool = tool;
  endtask

  task automatic run_random(input int n, input int hold_at);
    int start;
    int pick;
    bit held;
    start = sent_count;
    held  = (hold_at < 0);
    while (sent_count - start < n) begin
      if (!held && sent_count - start >= hold_at) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 65)
        send_random_frame(1'b0);
      else if (pick < 77)
        send_random_frame(1'b1);
      else if (pick < 95)
        send_setting();
      else
        send_req(OP_UNUSED, $urandom(), SLOT_W'($urandom_range(7)), $urandom());
    end
  endtask

  initial begin
    logic [WORD_W-1:0] w [FRAME_WORDS-1];
    rst                     = 1'b1;
    cfg_wr_en               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    item_if.valid           = 1'b0;
    item_if.opcode          = OP_FRAME_WORD;
    item_if.frame_word      = '0;
    item_if.tool_slot       = '0;
    item_if.wanted_position = '0;
    send_idle_pct           = 19;
    recv_idle_pct           = 51;
    sent_count              = 0;
    hold_req                = 1'b0;
    cur_tool                = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration.
    w = '{32'h0, 32'h0, 32'h0, 32'h0};
    send_frame(w, 1'b0, 1'b0);
    w = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
    send_frame(w, 1'b0, 1'b0);
    send_req(OP_SET_LONG, '0, 3'd0, 32'h8000_0000);
    send_req(OP_SET_CROSS, '1, 3'd0, 32'h7FFF_FFFF);
    send_req(OP_SET_LONG, '1, 3'd7, 32'hFFFF_FFFF);
    send_req(OP_SET_CROSS, '0, 3'd7, 32'h0);
    send_req(OP_UNUSED, '1, 3'd7, 32'hFFFF_FFFF);
    // A frame whose CRC word is wrong must leave the old values in place.
    w = '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0};
    send_frame(w, 1'b1, 1'b0);
    w = '{32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0010, 32'hFFFF_FFF0};
    send_frame(w, 1'b0, 1'b0);
    wait_idle();

    set_config(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 3'd7);
    run_random(200, 100);
    wait_idle();

    // A zero scale simply multiplies everything by zero.
    set_config(16'h0, 16'h0, 1'b1, 1'b0, 3'd3);
    run_random(50, -1);
    wait_idle();

    send_idle_pct = 51;
    recv_idle_pct = 19;
    set_config(16'h1, 16'h1, 1'b1, 1'b1, 3'd0);
    run_random(110, -1);
    wait_idle();
    set_config(SCALE_W'($urandom_range(1, 65535)), SCALE_W'($urandom_range(1, 65535)),
               1'b0, 1'b1, 3'd7);
    run_random(110, -1);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int p = 0; p < 4; p++) begin
      set_config(SCALE_W'($urandom_range(65535)), SCALE_W'($urandom_range(65535)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), SLOT_W'($urandom_range(7)));
      run_random(55, -1);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/apf_pkg.sv
rtl/apf_in_if.sv
rtl/apf_out_if.sv
rtl/axis_position_frame_with_tool_offsets.sv
tb/apf_tb_pkg.sv
tb/tb.sv
